@@ design/m2x2alu_pkg.sv @@
// shared types and constants of the 2x2 matrix unit
package m2x2alu_pkg;

   localparam int ELEMENT_WIDTH_DEF = 16;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int KIND_WIDTH        = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_ADD    = 3'd0,
      KIND_SUB    = 3'd1,
      KIND_MUL    = 3'd2,
      KIND_MATVEC = 3'd3,
      KIND_TRANS  = 3'd4,
      KIND_NEG    = 3'd5,
      KIND_INV    = 3'd6,
      KIND_DET    = 3'd7
   } kind_type;

endpackage

@@ design/m2x2alu_div_step.sv @@
// one restoring division step: one quotient bit
module m2x2alu_div_step #(
   parameter int REM_WIDTH = 34,
   parameter int DIV_WIDTH = 33,
   parameter int SHIFT     = 0
) (
   input  logic [REM_WIDTH-1:0] rem,
   input  logic [DIV_WIDTH-1:0] divisor,
   output logic [REM_WIDTH-1:0] rem_nxt,
   output logic                 take
);

   logic [REM_WIDTH-1:0] div_ext;

   assign div_ext = REM_WIDTH'(divisor);
   assign take    = (rem >> SHIFT) >= div_ext;
   assign rem_nxt = take ? (rem - (div_ext << SHIFT)) : rem;

endmodule

@@ design/matrix2x2_alu.sv @@
// throughput: one beat per cycle; a stall holds full stages only, bubbles are squeezed out
// depth is set by the inverse: a restoring divider with one quotient bit per stage
// stages: input, multiply, sum, round, divide range check, ELEMENT_WIDTH + 1 divide steps, output
// reset (synchronous) clears the valid bits only; the data registers are not reset
module matrix2x2_alu #(
   parameter int ELEMENT_WIDTH = m2x2alu_pkg::ELEMENT_WIDTH_DEF,
   parameter int FRACTION_BITS = m2x2alu_pkg::FRACTION_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // a00, a01, a10, a11, b00, b01, b10, b11
   input  logic [((8*ELEMENT_WIDTH+7)/8)*8-1:0]        req_tdata,
   // kind
   input  logic [m2x2alu_pkg::KIND_WIDTH-1:0]          req_tuser,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // r00, r01, r10, r11
   output logic [((4*ELEMENT_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // singular, overflow
   output logic [1:0]                                  rsp_tuser
);
   import m2x2alu_pkg::*;

   localparam int W      = ELEMENT_WIDTH;
   localparam int F      = FRACTION_BITS;
   localparam int MW     = 2*W + 1;
   localparam int NW     = ((W + 2*F > 2*W) ? W + 2*F : 2*W) + 1;
   localparam int LW     = NW + 1;
   localparam int DS     = W + 2;
   localparam int NS     = W + 7;
   localparam int OUT_DW = ((4*W+7)/8)*8;

   localparam logic signed [W:0] SMAX    = {2'b00, {(W-1){1'b1}}};
   localparam logic signed [W:0] SMIN    = {2'b11, {(W-1){1'b0}}};
   localparam logic [LW-1:0]     POS_LIM = LW'({(W-1){1'b1}});
   localparam logic [LW-1:0]     NEG_LIM = POS_LIM + LW'(1);
   localparam logic [LW-1:0]     HALF    = LW'((64'd1 << F) >> 1);

   typedef logic [3:0][W-1:0] quad_type;
   typedef struct packed {
      kind_type          kind;
      quad_type          a;
      quad_type          res;
      logic              rovf;
      logic              sing;
      logic [MW-1:0]     det;
      logic              det_neg;
      logic [3:0]        nneg;
   } ctl_type;

   // saturate a sign-magnitude value to the element range; msb is overflow
   function automatic logic [W:0] sat_mag(input logic neg, input logic [LW-1:0] m);
      logic [W-1:0] v;
      logic         o;
      o = 1'b0;
      if (!neg) begin
         if (m > POS_LIM) begin
            v = {1'b0, {(W-1){1'b1}}};
            o = 1'b1;
         end else begin
            v = W'(m);
         end
      end else begin
         if (m > NEG_LIM) begin
            v = {1'b1, {(W-1){1'b0}}};
            o = 1'b1;
         end else begin
            v = W'(-m);
         end
      end
      return {o, v};
   endfunction

   // stage control
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int i = NS-2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_tready = en[0];

   // stage 0: input register
   kind_type kind0_ff;
   quad_type a0_ff, b0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         kind0_ff <= kind_type'(req_tuser);
         a0_ff    <= req_tdata[4*W-1:0];
         b0_ff    <= req_tdata[8*W-1:4*W];
      end
   end

   // stage 1: products and the elementwise operations
   logic signed [2*W-1:0] prod_in [4][2];
   logic signed [2*W-1:0] prod_ff [4][2];
   quad_type              simple_in, simple_ff;
   logic                  sovf_in, sovf_ff;
   kind_type              kind1_ff;
   quad_type              a1_ff;
   logic                  det0;

   always_comb begin
      logic signed [W:0] s;
      int                tk;
      det0 = (kind0_ff == KIND_INV) || (kind0_ff == KIND_DET);
      prod_in[0][0] = $signed(a0_ff[0]) * $signed(det0 ? a0_ff[3] : b0_ff[0]);
      prod_in[0][1] = $signed(det0 ? a0_ff[1] : a0_ff[2]) * $signed(det0 ? a0_ff[2] : b0_ff[1]);
      prod_in[1][0] = $signed(a0_ff[1]) * $signed(b0_ff[0]);
      prod_in[1][1] = $signed(a0_ff[3]) * $signed(b0_ff[1]);
      prod_in[2][0] = $signed(a0_ff[0]) * $signed(b0_ff[2]);
      prod_in[2][1] = $signed(a0_ff[2]) * $signed(b0_ff[3]);
      prod_in[3][0] = $signed(a0_ff[1]) * $signed(b0_ff[2]);
      prod_in[3][1] = $signed(a0_ff[3]) * $signed(b0_ff[3]);
      sovf_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         tk = (k == 1) ? 2 : ((k == 2) ? 1 : k);
         unique case (kind0_ff)
            KIND_ADD:   s = (W+1)'($signed(a0_ff[k])) + (W+1)'($signed(b0_ff[k]));
            KIND_SUB:   s = (W+1)'($signed(a0_ff[k])) - (W+1)'($signed(b0_ff[k]));
            KIND_NEG:   s = -(W+1)'($signed(a0_ff[k]));
            KIND_TRANS: s = (W+1)'($signed(a0_ff[tk]));
            default:    s = '0;
         endcase
         if (s > SMAX) begin
            simple_in[k] = W'(SMAX);
            sovf_in      = 1'b1;
         end else if (s < SMIN) begin
            simple_in[k] = W'(SMIN);
            sovf_in      = 1'b1;
         end else begin
            simple_in[k] = W'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         prod_ff   <= prod_in;
         simple_ff <= simple_in;
         sovf_ff   <= sovf_in;
         kind1_ff  <= kind0_ff;
         a1_ff     <= a0_ff;
      end
   end

   // stage 2: exact sums in sign-magnitude form
   logic [MW-1:0] mag_in [4];
   logic [MW-1:0] mag2_ff [4];
   logic [3:0]    neg_in, neg2_ff;
   quad_type      simple2_ff, a2_ff;
   logic          sovf2_ff;
   kind_type      kind2_ff;

   always_comb begin
      logic signed [MW-1:0] s;
      logic                 sub;
      for (int k = 0; k < 4; k++) begin
         sub = (k == 0) && ((kind1_ff == KIND_INV) || (kind1_ff == KIND_DET));
         s = sub ? (MW'(prod_ff[k][0]) - MW'(prod_ff[k][1]))
                 : (MW'(prod_ff[k][0]) + MW'(prod_ff[k][1]));
         neg_in[k] = s[MW-1];
         mag_in[k] = s[MW-1] ? MW'(-s) : MW'(s);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         mag2_ff    <= mag_in;
         neg2_ff    <= neg_in;
         simple2_ff <= simple_ff;
         sovf2_ff   <= sovf_ff;
         kind2_ff   <= kind1_ff;
         a2_ff      <= a1_ff;
      end
   end

   // stage 3: rounding, per-kind selection, divider numerators
   ctl_type       ctl3_in, ctl3_ff;
   logic [NW-1:0] num_in [4];
   logic [NW-1:0] num3_ff [4];

   always_comb begin
      logic [W:0]   sr [4];
      logic [W-1:0] nv;
      logic [W-1:0] absn;
      logic         nn;
      int           src;
      for (int k = 0; k < 4; k++) begin
         sr[k] = sat_mag(neg2_ff[k], (LW'(mag2_ff[k]) + HALF) >> F);
      end
      ctl3_in.kind    = kind2_ff;
      ctl3_in.a       = a2_ff;
      ctl3_in.det     = mag2_ff[0];
      ctl3_in.det_neg = neg2_ff[0];
      ctl3_in.sing    = (mag2_ff[0] == '0);
      unique case (kind2_ff)
         KIND_MUL: begin
            for (int k = 0; k < 4; k++) ctl3_in.res[k] = sr[k][W-1:0];
            ctl3_in.rovf = sr[0][W] | sr[1][W] | sr[2][W] | sr[3][W];
         end
         KIND_MATVEC: begin
            ctl3_in.res  = {{(2*W){1'b0}}, sr[1][W-1:0], sr[0][W-1:0]};
            ctl3_in.rovf = sr[0][W] | sr[1][W];
         end
         KIND_DET: begin
            ctl3_in.res  = {{(3*W){1'b0}}, sr[0][W-1:0]};
            ctl3_in.rovf = sr[0][W];
         end
         default: begin
            ctl3_in.res  = simple2_ff;
            ctl3_in.rovf = sovf2_ff;
         end
      endcase
      // inverse numerators: a11, -a01, -a10, a00
      for (int k = 0; k < 4; k++) begin
         src  = (k == 0) ? 3 : ((k == 3) ? 0 : k);
         nv   = a2_ff[src];
         absn = nv[W-1] ? W'(-nv) : nv;
         nn   = (k == 0 || k == 3) ? nv[W-1] : (!nv[W-1] && nv != '0);
         ctl3_in.nneg[k] = nn;
         num_in[k] = (NW'(absn) << (2*F)) + NW'(mag2_ff[0] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ctl3_ff <= ctl3_in;
         num3_ff <= num_in;
      end
   end

   // divider: index 0 checks range, then one quotient bit per stage, msb first
   ctl_type       ctl_ff  [DS];
   logic [NW-1:0] drem_ff [DS][4];
   logic [W:0]    q_ff    [DS][4];
   logic [3:0]    over_ff [DS];
   logic [3:0]    over_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         over_in[k] = (num3_ff[k] >> (W+1)) >= NW'(ctl3_ff.det);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         ctl_ff[0]  <= ctl3_ff;
         drem_ff[0] <= num3_ff;
         over_ff[0] <= over_in;
         for (int k = 0; k < 4; k++) q_ff[0][k] <= '0;
      end
   end

   for (genvar j = 1; j < DS; j++) begin : g_div
      logic [NW-1:0] rem_in [4];
      logic [3:0]    bit_in;
      for (genvar k = 0; k < 4; k++) begin : g_lane
         m2x2alu_div_step #(
            .REM_WIDTH (NW),
            .DIV_WIDTH (MW),
            .SHIFT     (DS - 1 - j)
         ) u_step (
            .rem     (drem_ff[j-1][k]),
            .divisor (ctl_ff[j-1].det),
            .rem_nxt (rem_in[k]),
            .take    (bit_in[k])
         );
      end
      always_ff @(posedge clock) begin
         if (en[4+j]) begin
            ctl_ff[j]  <= ctl_ff[j-1];
            drem_ff[j] <= rem_in;
            over_ff[j] <= over_ff[j-1];
            for (int k = 0; k < 4; k++) begin
               q_ff[j][k] <= {q_ff[j-1][k][W-1:0], bit_in[k]};
            end
         end
      end
   end

   // output stage
   quad_type   r_in, r_ff;
   logic       sing_in, sing_ff, ovf_in, ovf_ff;
   kind_type   kind_out_ff;

   always_comb begin
      logic [W:0]    sq [4];
      logic [LW-1:0] m;
      logic          qneg;
      ctl_type       c;
      c = ctl_ff[DS-1];
      for (int k = 0; k < 4; k++) begin
         m     = over_ff[DS-1][k] ? {LW{1'b1}} : LW'(q_ff[DS-1][k]);
         qneg  = (c.nneg[k] != c.det_neg) && (m != '0);
         sq[k] = sat_mag(qneg, m);
      end
      if (c.kind == KIND_INV) begin
         if (c.sing) begin
            r_in    = c.a;
            sing_in = 1'b1;
            ovf_in  = 1'b0;
         end else begin
            for (int k = 0; k < 4; k++) r_in[k] = sq[k][W-1:0];
            sing_in = 1'b0;
            ovf_in  = sq[0][W] | sq[1][W] | sq[2][W] | sq[3][W];
         end
      end else begin
         r_in    = c.res;
         sing_in = 1'b0;
         ovf_in  = c.rovf;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         r_ff        <= r_in;
         sing_ff     <= sing_in;
         ovf_ff      <= ovf_in;
         kind_out_ff <= ctl_ff[DS-1].kind;
      end
   end

   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata  = OUT_DW'(r_ff);
   assign rsp_tuser  = {ovf_ff, sing_ff};

   // a singular inverse passes the matrix through without saturation
   a_sing_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && sing_ff |-> !ovf_ff)
      else $error("singular result flagged overflow");

   a_sing_inv_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind_out_ff != KIND_INV |-> !sing_ff)
      else $error("singular set on a non-inverse beat");

   a_matvec_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (kind_out_ff == KIND_MATVEC || kind_out_ff == KIND_DET)
         |-> r_ff[2] == '0 && r_ff[3] == '0)
      else $error("unused result rows not zero");

   // back-pressure reaches the input only when every stage is full and the output stalls
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready && (&v_ff))
      else $error("input stalled with room in the pipeline");

endmodule

@@ tb/matrix2x2_checker.sv @@
// checker for the 2x2 matrix unit: predicts each result beat and compares it
`timescale 1ns / 100ps
module matrix2x2_checker
   import m2x2alu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [15:0] r11, r10, r01, r00;
      logic        singular;
      logic        overflow;
   } matrix_result_t;

   matrix_result_t expected_results[$];
   bit ovf;

   localparam longint EMAX = 32767;

   // round-to-nearest magnitude then saturate
   function automatic longint sat_round(longint v, int shift);
      longint m;
      bit neg;
      neg = v < 0;
      m = neg ? -v : v;
      if (shift > 0) m = (m + (longint'(1) << (shift - 1))) >>> shift;
      if (m == 0) return 0;
      if (!neg) begin
         if (m > EMAX) begin
            ovf = 1;
            return EMAX;
         end
         return m;
      end
      if (m > EMAX + 1) begin
         ovf = 1;
         return -EMAX - 1;
      end
      return -m;
   endfunction

   function automatic longint div_by_det(longint e, longint det);
      longint n, d, q;
      n = e < 0 ? -e : e;
      d = det < 0 ? -det : det;
      q = ((n << 16) + d / 2) / d;
      if ((e < 0) != (det < 0)) q = -q;
      return sat_round(q, 0);
   endfunction

   function automatic matrix_result_t compute_matrix(logic [2:0] kind, logic [127:0] d);
      longint a00, a01, a10, a11, b00, b01, b10, b11, det;
      longint r[4];
      matrix_result_t res;
      a00 = $signed(d[15:0]);    a01 = $signed(d[31:16]);
      a10 = $signed(d[47:32]);   a11 = $signed(d[63:48]);
      b00 = $signed(d[79:64]);   b01 = $signed(d[95:80]);
      b10 = $signed(d[111:96]);  b11 = $signed(d[127:112]);
      r = '{0, 0, 0, 0};
      ovf = 0;
      res = '0;
      case (kind_type'(kind))
         KIND_ADD: begin
            r[0] = sat_round(a00 + b00, 0); r[1] = sat_round(a01 + b01, 0);
            r[2] = sat_round(a10 + b10, 0); r[3] = sat_round(a11 + b11, 0);
         end
         KIND_SUB: begin
            r[0] = sat_round(a00 - b00, 0); r[1] = sat_round(a01 - b01, 0);
            r[2] = sat_round(a10 - b10, 0); r[3] = sat_round(a11 - b11, 0);
         end
         KIND_MUL: begin
            r[0] = sat_round(a00 * b00 + a10 * b01, 8);
            r[1] = sat_round(a01 * b00 + a11 * b01, 8);
            r[2] = sat_round(a00 * b10 + a10 * b11, 8);
            r[3] = sat_round(a01 * b10 + a11 * b11, 8);
         end
         KIND_MATVEC: begin
            r[0] = sat_round(a00 * b00 + a10 * b01, 8);
            r[1] = sat_round(a01 * b00 + a11 * b01, 8);
         end
         KIND_TRANS: r = '{a00, a10, a01, a11};
         KIND_NEG: begin
            r[0] = sat_round(-a00, 0); r[1] = sat_round(-a01, 0);
            r[2] = sat_round(-a10, 0); r[3] = sat_round(-a11, 0);
         end
         KIND_INV: begin
            det = a00 * a11 - a01 * a10;
            if (det == 0) begin
               res.singular = 1;
               r = '{a00, a01, a10, a11};
            end else begin
               r[0] = div_by_det(a11, det);  r[1] = div_by_det(-a01, det);
               r[2] = div_by_det(-a10, det); r[3] = div_by_det(a00, det);
            end
         end
         default: r[0] = sat_round(a00 * a11 - a01 * a10, 8);
      endcase
      res.r00 = r[0][15:0];
      res.r01 = r[1][15:0];
      res.r10 = r[2][15:0];
      res.r11 = r[3][15:0];
      res.overflow = ovf;
      return res;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      matrix_result_t got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(compute_matrix(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser[0], rsp_tuser[1]};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected beat, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch r00/r01/r10/r11 sing ovf expected %h %h %h %h %b %b",
                           $time, want.r00, want.r01, want.r10, want.r11,
                           want.singular, want.overflow);
                  $display("%0t:                                 actual %h %h %h %h %b %b",
                           $time, got.r00, got.r01, got.r10, got.r11,
                           got.singular, got.overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ tb/tb.sv @@
// testbench top: stimulus for the 2x2 matrix unit and the verdict
`timescale 1ns / 100ps
module tb;
   import m2x2alu_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   int           fail_count;
   int           pending;
   bit           hold_off = 0;
   bit           stim_done = 0;

   always #2 clock = ~clock;

   matrix2x2_alu u_dut (.*);
   matrix2x2_checker u_chk (.*);

   function automatic logic [15:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         4, 5: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // valid stays up into the next beat when there is no gap
   task automatic send_beat(kind_type kind, logic [127:0] data);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random();
      logic [127:0] d;
      kind_type k;
      k = kind_type'($urandom_range(0, 7));
      for (int i = 0; i < 8; i++) d[i*16 +: 16] = pick_element();
      // singular matrices for invert: copy the first column into the second
      if (k == KIND_INV && $urandom_range(0, 3) == 0) begin
         d[31:16] = d[15:0];
         d[63:48] = d[47:32];
      end
      send_beat(k, d);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
         if (wait_cycles > 0) begin
            rsp_tready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // extremes of each field for every operation
      for (int k = 0; k < 8; k++) begin
         send_beat(kind_type'(k), {8{16'h8000}});
         send_beat(kind_type'(k), {8{16'h7fff}});
      end
      send_beat(KIND_INV, {64'h0, 16'h0200, 16'h0100, 16'h0100, 16'h0200});
      send_beat(KIND_INV, {64'h0, 16'h0100, 16'h0000, 16'h0000, 16'h0100});
      send_beat(KIND_INV, {64'h0, 16'h0000, 16'h0001, 16'h0001, 16'h0000});
      send_beat(KIND_NEG, {64'h0, 16'h0001, 16'hffff, 16'h0000, 16'h8000});
      send_beat(KIND_MUL, {16'h0080, 16'hff80, 16'h0080, 16'hff80, {4{16'h0001}}});
      send_beat(KIND_DET, {64'h0, 16'h0001, 16'h0000, 16'h0000, 16'h0080});
      hold_off = 1;
      for (int i = 0; i < 1000; i++) send_random();
      req_tvalid <= 0;
      // pause until drained
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      for (int i = 0; i < 1000; i++) send_random();
      req_tvalid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
design/m2x2alu_pkg.sv
design/m2x2alu_div_step.sv
design/matrix2x2_alu.sv
tb/matrix2x2_checker.sv
tb/tb.sv
